[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TBM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared constants, codes and controller/datapath interface types for the
// tombstone bitmap merge block.
// ----------------------------------------------------------------------------
package tbm_pkg;

	// Mapping store geometry
	localparam int ROWS   = 4096;
	localparam int ADDR_W = $clog2(ROWS);

	// Field widths
	localparam int CMD_W   = 2;
	localparam int ROW_W   = 12;
	localparam int TID_W   = 64;
	localparam int SLICE_W = 13;
	localparam int CNT_W   = 13;

	// Stream widths
	localparam int IN_W  = 96;
	localparam int OUT_W = 32;

	// Input tdata layout, lowest bit first
	localparam int IN_ROW_LO   = 0;
	localparam int IN_TID_LO   = IN_ROW_LO + ROW_W;
	localparam int IN_DEL_LO   = IN_TID_LO + TID_W;
	localparam int IN_LOCAL_LO = IN_DEL_LO + 1;
	localparam int IN_FIRST_LO = IN_LOCAL_LO + ROW_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_DIRECT = 2'd0;
	localparam logic [1:0] REG_START  = 2'd1;
	localparam logic [1:0] REG_END    = 2'd2;

	localparam logic [SLICE_W-1:0] END_RESET = 13'd4096;
	localparam logic [CNT_W-1:0]   CNT_MAX   = 13'h1FFF;

	// Controller to datapath strobes
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic dwait;
		logic rdwait;
		logic mark;
		logic push;
	} ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             direct;
		logic             in_slice;
		logic             scan_hit;
		logic             scan_miss;
		logic             out_free;
	} stat_t;

endpackage

[rtl/tombstone_bitmap_merge_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tombstone_bitmap_merge_top
// Row-to-tuple-id store with a deleted bitmap; applies tombstone entries by
// direct row index or by a forward tuple-id merge.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item returns one result. Load
// and unknown commands go straight to the result register; a read waits for
// the registered memory read; a direct apply outside the slice goes straight
// to the result, and inside it reads the deleted bit and then marks the row.
// A merge apply walks mapping rows from the cursor until a tuple-id match,
// which marks the row, or the slice end. The single-port mapping memory is
// read one row per cycle, with registered read data. s_tready rises with the
// result, so the next transfer in can come once the result is loaded, even
// while that result still waits in the output register; a stalled output
// holds the following result in its last step. Mapping and deleted stores
// are undefined until loaded.
// ----------------------------------------------------------------------------
module tombstone_bitmap_merge_top import tbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [SLICE_W-1:0] cfg_data,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,  // row, tuple_id, deleted_in, local_index, first_entry
	input  logic [CMD_W-1:0]   s_tuser,  // cmd
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata   // hit, newly_set, hit_row, applied_total, deleted_out
);

	ctrl_t ctl;
	stat_t st;

	tbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	tbm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[rtl/tbm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/tbm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_ctrl
// Command sequencer: takes one item at a time and steps the datapath through
// load, read or apply, then hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbm_ctrl import tbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t st,
	output ctrl_t ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DWAIT  = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_MARK   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		ctl         = '0;
		ctl.capture = s_tready & s_tvalid;
		ctl.exec    = (state_q == S_EXEC);
		ctl.scan    = (state_q == S_SCAN);
		ctl.dwait   = (state_q == S_DWAIT);
		ctl.rdwait  = (state_q == S_RDWAIT);
		ctl.mark    = (state_q == S_MARK);
		ctl.push    = (state_q == S_DONE) & st.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (st.cmd)
					CMD_LOAD:  state_d = S_DONE;
					CMD_READ:  state_d = S_RDWAIT;
					CMD_APPLY: begin
						if (!st.direct) state_d = S_SCAN;
						else if (st.in_slice) state_d = S_DWAIT;
						else state_d = S_DONE;
					end
					CMD_NOP:   state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (st.scan_hit) state_d = S_MARK;
				else if (st.scan_miss) state_d = S_DONE;
			end
			S_DWAIT:  state_d = S_MARK;
			S_RDWAIT: state_d = S_DONE;
			S_MARK:   state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TBM_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state_q == S_EXEC, "accept did not start execution")
	`TBM_ASSERT(a_scan_exclusive, !(st.scan_hit && st.scan_miss && ctl.scan), "scan hit and miss together")

endmodule

[rtl/tbm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_dp
// Datapath: configuration registers, item registers, mapping and deleted
// stores, merge cursor, applied count and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbm_dp import tbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctl,
	output stat_t              st,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [SLICE_W-1:0] cfg_data,
	input  logic [IN_W-1:0]    s_tdata,
	input  logic [CMD_W-1:0]   s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata
);

	// Configuration
	logic               direct_q;
	logic [SLICE_W-1:0] start_q;
	logic [SLICE_W-1:0] end_q;

	// Current item
	logic [CMD_W-1:0] cmd_q;
	logic [ROW_W-1:0] row_q;
	logic [TID_W-1:0] tid_q;
	logic             del_in_q;
	logic [ROW_W-1:0] local_q;
	logic             first_q;

	// Walk and count state
	logic [SLICE_W-1:0] cursor_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLICE_W-1:0] probe_q;
	logic               pend_q;
	logic [SLICE_W-1:0] pend_row_q;
	logic [SLICE_W-1:0] target_q;
	logic               hit_del_q;

	// Result fields
	logic             res_hit_q;
	logic             res_new_q;
	logic [ROW_W-1:0] res_row_q;
	logic             res_del_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [SLICE_W-1:0] bound_c;
	logic [SLICE_W:0]   tgt_sum_c;
	logic               in_slice_c;
	logic               row_ok_c;
	logic               issue_c;
	logic               match_c;
	logic               load_we_c;
	logic               mark_we_c;
	logic [ADDR_W-1:0]  ram_addr_c;
	logic [TID_W-1:0]   rd_tid;
	logic               rd_del;
	logic [CNT_W-1:0]   total_c;

	assign bound_c    = (32'(end_q) < 32'(ROWS)) ? end_q : SLICE_W'(ROWS);
	assign tgt_sum_c  = (SLICE_W+1)'(start_q) + (SLICE_W+1)'(local_q);
	assign in_slice_c = 32'(tgt_sum_c) < 32'(bound_c);
	assign row_ok_c   = 32'(row_q) < 32'(ROWS);
	assign issue_c    = probe_q < bound_c;
	assign match_c    = pend_q && (rd_tid == tid_q);
	assign load_we_c  = ctl.exec && (cmd_q == CMD_LOAD) && row_ok_c;
	assign mark_we_c  = ctl.mark && !hit_del_q;

	always_comb begin
		priority if (ctl.scan) begin
			ram_addr_c = ADDR_W'(probe_q);
		end else if (ctl.mark) begin
			ram_addr_c = ADDR_W'(target_q);
		end else if (ctl.exec && cmd_q == CMD_APPLY && direct_q) begin
			ram_addr_c = ADDR_W'(tgt_sum_c);
		end else begin
			ram_addr_c = ADDR_W'(row_q);
		end
	end

	tbm_ram #(.WIDTH(TID_W), .DEPTH(ROWS)) u_tid_ram (
		.clk   (clk),
		.we    (load_we_c),
		.addr  (ram_addr_c),
		.wdata (tid_q),
		.rdata (rd_tid)
	);

	tbm_ram #(.WIDTH(1), .DEPTH(ROWS)) u_del_ram (
		.clk   (clk),
		.we    (load_we_c | mark_we_c),
		.addr  (ram_addr_c),
		.wdata (load_we_c ? del_in_q : 1'b1),
		.rdata (rd_del)
	);

	always_comb begin
		st           = '0;
		st.cmd       = cmd_q;
		st.direct    = direct_q;
		st.in_slice  = in_slice_c;
		st.scan_hit  = match_c;
		st.scan_miss = !pend_q && !issue_c;
		st.out_free  = !m_tvalid_q || m_tready;
	end

	assign total_c = (cmd_q == CMD_APPLY) ? count_q : '0;

	// Item and result payload
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= s_tuser;
			row_q    <= s_tdata[IN_ROW_LO +: ROW_W];
			tid_q    <= s_tdata[IN_TID_LO +: TID_W];
			del_in_q <= s_tdata[IN_DEL_LO];
			local_q  <= s_tdata[IN_LOCAL_LO +: ROW_W];
			first_q  <= s_tdata[IN_FIRST_LO];
		end
		if (ctl.exec) begin
			res_hit_q <= 1'b0;
			res_new_q <= 1'b0;
			res_row_q <= '0;
			res_del_q <= 1'b0;
			target_q  <= SLICE_W'(tgt_sum_c);
			probe_q   <= first_q ? start_q : cursor_q;
		end
		if (ctl.scan) begin
			if (match_c) begin
				target_q  <= pend_row_q;
				hit_del_q <= rd_del;
			end else if (issue_c || pend_q) begin
				pend_row_q <= probe_q;
				if (issue_c) probe_q <= probe_q + 1'b1;
			end
		end
		if (ctl.dwait) hit_del_q <= rd_del;
		if (ctl.rdwait) res_del_q <= row_ok_c & rd_del;
		if (ctl.mark) begin
			res_hit_q <= 1'b1;
			res_row_q <= target_q[ROW_W-1:0];
			res_new_q <= !hit_del_q;
		end
		if (ctl.push) begin
			m_tdata_q <= {4'b0, res_del_q, total_c, res_row_q, res_new_q, res_hit_q};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_q   <= 1'b0;
			start_q    <= '0;
			end_q      <= END_RESET;
			cursor_q   <= '0;
			count_q    <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIRECT: direct_q <= cfg_data[0];
					REG_START:  start_q  <= cfg_data;
					REG_END:    end_q    <= cfg_data;
					default:    ;
				endcase
			end
			if (ctl.exec) begin
				pend_q <= 1'b0;
				if (cmd_q == CMD_APPLY && first_q) begin
					cursor_q <= start_q;
					count_q  <= '0;
				end
			end
			if (ctl.scan) begin
				if (match_c) begin
					cursor_q <= pend_row_q + 1'b1;
				end else if (!pend_q && !issue_c) begin
					if (cursor_q < bound_c) cursor_q <= bound_c;
				end else begin
					pend_q <= issue_c;
				end
			end
			if (mark_we_c && count_q != CNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`TBM_ASSERT(a_no_overwrite, (m_tvalid_q && !m_tready) |-> !ctl.push, "result overwritten while stalled")
	`TBM_ASSERT(a_mark_in_slice, ctl.mark |-> (target_q < bound_c), "marked row outside slice")
	`TBM_ASSERT_NEXT(a_count_mono, !ctl.exec, count_q >= $past(count_q), "applied count dropped without first entry")
	`TBM_ASSERT_NEXT(a_cursor_hit, ctl.scan && match_c, cursor_q == $past(pend_row_q) + 1'b1, "cursor not past hit row")

endmodule
